>>> design/qpr_pkg.sv
// qpr_pkg: shared types and constants for quaternion_point_rotation.
// No dependencies.
package qpr_pkg;

  // conjugate sequencer states
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_NORM,
    CS_LOAD,
    CS_DIV,
    CS_SQRT
  } conj_state_t;

  localparam int REG_IDX_W = 2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_ROT_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROT_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROT_Z = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROT_W = 2'd3;

endpackage

>>> design/quaternion_point_rotation.sv
// quaternion_point_rotation: rotates Q16.16 points by a configured Q2.14 quaternion.
// Depends on qpr_pkg (state type, register indexes).
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tdata: pos_x, pos_y, pos_z
//  out_    | out | out_tvalid / out_tready| tdata: out_x, out_y, out_z; tuser: clipped
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (rot_x..rot_w)
//
// Datapath: five register stages, one point per cycle unless out_tready is low
// or the sequencer is busy. Each stage holds its data while the next one is
// full and stalled; a bubble is filled by the stage behind it, so no transfer
// is lost or repeated. After every config transfer a sequencer rebuilds the
// unit conjugate with one shared restoring divider and one square-root unit:
// it sums the squared components into the norm, then per component loads,
// divides and takes the square root. in_tready stays low meanwhile. Reset loads
// the identity rotation and its conjugate directly, so no pass runs after reset.
module quaternion_point_rotation #(
  parameter int COORD_WIDTH = 32,
  parameter int QUAT_WIDTH  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata, from bit 0: pos_x, pos_y, pos_z, zero fill
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  // out_tdata, from bit 0: out_x, out_y, out_z, zero fill
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // out_tuser, bit 0: clipped
  output logic                           out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qpr_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [QUAT_WIDTH-1:0]          cfg_data
);
  import qpr_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int QW   = QUAT_WIDTH;
  localparam int QF   = QW - 2;
  localparam int DW   = ((3*CW+7)/8)*8;
  localparam int PW   = QW + CW;        // q*p product
  localparam int TW   = PW + 2;         // t sum
  localparam int OPW  = TW + QW;        // t*c product
  localparam int OW   = OPW + 2;        // o sum
  localparam int NW   = 2*QW + 1;       // norm
  localparam int RW   = 2*QW + 2;       // divider remainder
  localparam int QB   = 2*QW - 1;       // quotient bits
  localparam int DIV_STEPS  = 2*QW - 1;
  localparam int SQRT_STEPS = QW;
  localparam int CNT_W = $clog2(2*QW);
  localparam logic signed [OW-1:0] HALF = OW'(1) << (2*QF-1);

  // ---------------- configuration registers ----------------
  logic signed [QW-1:0] rot_r [4];
  logic signed [QW-1:0] conj_r [4];
  logic signed [QW-1:0] conj_nxt [4];
  logic cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[REG_ROT_X] <= '0;
      rot_r[REG_ROT_Y] <= '0;
      rot_r[REG_ROT_Z] <= '0;
      rot_r[REG_ROT_W] <= QW'(1) << QF;
    end else if (cfg_fire) begin
      rot_r[cfg_index] <= cfg_data;
    end
  end

  // ---------------- conjugate sequencer ----------------
  conj_state_t cs_r, cs_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [QB-1:0]    quo_r, quo_nxt;
  logic [QB-1:0]    sv_r, sv_nxt;
  logic [QB:0]      sres_r, sres_nxt;
  logic [QB-1:0]    sbit_r, sbit_nxt;

  logic signed [QW-1:0] a_sel;
  logic [QW-1:0]   mag_in;
  logic [2*QW-1:0] msq;
  logic [RW-1:0]   dsh;
  logic [NW-1:0]   nsum;
  logic [QB:0]     strial;
  logic [QW-1:0]   umag;
  logic            negate;

  always_comb begin
    a_sel  = rot_r[idx_r];
    mag_in = a_sel[QW-1] ? QW'(-a_sel) : QW'(a_sel);
    msq    = (2*QW)'(mag_in) * (2*QW)'(mag_in);
  end

  always_comb begin
    cs_nxt   = cs_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    sv_nxt   = sv_r;
    sres_nxt = sres_r;
    sbit_nxt = sbit_r;
    conj_nxt = conj_r;
    nsum     = n_r + NW'(msq);
    dsh      = (cnt_r == '0) ? rem_r : {rem_r[RW-2:0], 1'b0};
    strial   = sres_r + (QB+1)'(sbit_r);
    umag     = '0;
    negate   = 1'b0;
    case (cs_r)
      CS_IDLE: ;
      CS_NORM: begin
        n_nxt   = nsum;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == REG_ROT_W) begin
          if (nsum == '0) begin
            // zero quaternion: conjugate left unscaled, i.e. all zero
            for (int k = 0; k < 4; k++) conj_nxt[k] = '0;
            cs_nxt = CS_IDLE;
          end else begin
            cs_nxt = CS_LOAD;
          end
        end
      end
      CS_LOAD: begin
        rem_nxt = RW'(msq);
        quo_nxt = '0;
        cnt_nxt = '0;
        cs_nxt  = CS_DIV;
      end
      CS_DIV: begin
        if (dsh >= RW'(n_r)) begin
          rem_nxt = dsh - RW'(n_r);
          quo_nxt = {quo_r[QB-2:0], 1'b1};
        end else begin
          rem_nxt = dsh;
          quo_nxt = {quo_r[QB-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS-1)) begin
          sv_nxt   = quo_nxt;
          sres_nxt = '0;
          sbit_nxt = QB'(1) << (QB-1);
          cnt_nxt  = '0;
          cs_nxt   = CS_SQRT;
        end
      end
      CS_SQRT: begin
        if ((QB+1)'(sv_r) >= strial) begin
          sv_nxt   = QB'((QB+1)'(sv_r) - strial);
          sres_nxt = (sres_r >> 1) + (QB+1)'(sbit_r);
        end else begin
          sres_nxt = sres_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SQRT_STEPS-1)) begin
          umag   = QW'((sres_nxt + (QB+1)'(1)) >> 1);
          // x, y, z take the sign of -a, w the sign of a
          negate = a_sel[QW-1] ^ (idx_r != REG_ROT_W);
          conj_nxt[idx_r] = negate ? QW'(-umag) : umag;
          idx_nxt = idx_r + 2'd1;
          cs_nxt  = (idx_r == REG_ROT_W) ? CS_IDLE : CS_LOAD;
        end
      end
      default: cs_nxt = CS_IDLE;
    endcase
    if (cfg_fire) begin
      cs_nxt  = CS_NORM;
      idx_nxt = '0;
      n_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r  <= CS_IDLE;
      idx_r <= '0;
      cnt_r <= '0;
      conj_r[REG_ROT_X] <= '0;
      conj_r[REG_ROT_Y] <= '0;
      conj_r[REG_ROT_Z] <= '0;
      conj_r[REG_ROT_W] <= QW'(1) << QF;
    end else begin
      cs_r   <= cs_nxt;
      idx_r  <= idx_nxt;
      cnt_r  <= cnt_nxt;
      conj_r <= conj_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    sv_r   <= sv_nxt;
    sres_r <= sres_nxt;
    sbit_r <= sbit_nxt;
  end

  // ---------------- pipeline control ----------------
  logic [5:1] v_r;
  logic [5:1] en;
  logic       in_fire;

  always_comb begin
    en[5] = ~v_r[5] | out_tready;
    for (int s = 4; s >= 1; s--) en[s] = ~v_r[s] | en[s+1];
  end

  assign in_tready  = en[1] & (cs_r == CS_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_tvalid = v_r[5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_fire;
      for (int s = 2; s <= 5; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // ---------------- stage 1: q * p products ----------------
  logic signed [CW-1:0] pos [3];
  logic signed [PW-1:0] qp_r [4][3];   // [q x,y,z,w][p x,y,z]

  assign pos[0] = in_tdata[CW-1:0];
  assign pos[1] = in_tdata[2*CW-1:CW];
  assign pos[2] = in_tdata[3*CW-1:2*CW];

  always_ff @(posedge clk) begin
    if (en[1] && in_fire) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 3; j++)
          qp_r[i][j] <= PW'(rot_r[i]) * PW'(pos[j]);
    end
  end

  // ---------------- stage 2: t = q * p ----------------
  logic signed [TW-1:0] t_r [4];   // w, x, y, z
  logic signed [TW-1:0] qe [4][3];

  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++)
        qe[i][j] = TW'(qp_r[i][j]);
  end

  always_ff @(posedge clk) begin
    if (en[2] && v_r[1]) begin
      t_r[0] <= -qe[0][0] - qe[1][1] - qe[2][2];
      t_r[1] <=  qe[3][0] + qe[1][2] - qe[2][1];
      t_r[2] <=  qe[3][1] + qe[2][0] - qe[0][2];
      t_r[3] <=  qe[3][2] + qe[0][1] - qe[1][0];
    end
  end

  // ---------------- stage 3: t * conj products ----------------
  logic signed [OPW-1:0] tc_r [4][4];  // [t w,x,y,z][c x,y,z,w]

  always_ff @(posedge clk) begin
    if (en[3] && v_r[2]) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          tc_r[i][j] <= OPW'(t_r[i]) * OPW'(conj_r[j]);
    end
  end

  // ---------------- stage 4: vector part, round, scale ----------------
  logic signed [OW-1:0] osum [3];
  logic signed [OW-1:0] te [4][4];
  logic signed [OW-1:0] r_r [3];

  always_comb begin
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        te[i][j] = OW'(tc_r[i][j]);
    // t index: 0 w, 1 x, 2 y, 3 z; c index: 0 x, 1 y, 2 z, 3 w
    osum[0] = te[1][3] + te[0][0] + te[2][2] - te[3][1];
    osum[1] = te[2][3] + te[0][1] + te[3][0] - te[1][2];
    osum[2] = te[3][3] + te[0][2] + te[1][1] - te[2][0];
  end

  always_ff @(posedge clk) begin
    if (en[4] && v_r[3]) begin
      for (int k = 0; k < 3; k++) r_r[k] <= (osum[k] + HALF) >>> (2*QF);
    end
  end

  // ---------------- stage 5: saturate, output register ----------------
  logic [CW-1:0] res_r [3];
  logic [CW-1:0] res_nxt [3];
  logic          clip_r, clip_nxt;
  logic          fits;

  always_comb begin
    clip_nxt = 1'b0;
    fits     = 1'b0;
    for (int k = 0; k < 3; k++) begin
      fits = (r_r[k][OW-1:CW-1] == '0) || (r_r[k][OW-1:CW-1] == '1);
      if (fits) begin
        res_nxt[k] = r_r[k][CW-1:0];
      end else begin
        clip_nxt   = 1'b1;
        res_nxt[k] = r_r[k][OW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5] && v_r[4]) begin
      res_r  <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_tdata = DW'({res_r[2], res_r[1], res_r[0]});
  assign out_tuser = clip_r;

endmodule

>>> verif/qpr_checker.sv
// qpr_checker: watches the point and result channels of quaternion_point_rotation,
// predicts every rotated point and compares it field by field. Depends on qpr_pkg.
`timescale 1ns / 1ps

module qpr_checker #(
  parameter int COORD_WIDTH = 32,
  parameter int QUAT_WIDTH  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  input  logic                               out_tuser,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [qpr_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [QUAT_WIDTH-1:0]              cfg_data,
  output int                                 fail_count,
  output int                                 pending
);
  import qpr_pkg::*;

  localparam int FRAC = QUAT_WIDTH - 2;

  typedef struct packed {
    logic                   clipped;
    logic [COORD_WIDTH-1:0] z;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] x;
  } rotated_pt_t;

  logic signed [QUAT_WIDTH-1:0] q_x, q_y, q_z, q_w;
  logic signed [QUAT_WIDTH-1:0] c_x, c_y, c_z, c_w;   // unit conjugate
  rotated_pt_t expected_pts[$];

  // floor sqrt of a wide value
  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] r, b;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      b = r | (128'd1 << i);
      if (b * b <= v) r = b;
    end
    return r;
  endfunction

  // round(|a| * 2^F / sqrt(n)), ties up: floor(sqrt(a^2 * 2^(2F+2) / n)) then halve up
  function automatic logic signed [QUAT_WIDTH-1:0] unit_part(
      input logic signed [QUAT_WIDTH-1:0] a, input logic [127:0] n, input bit flip);
    logic [127:0] m, quo, mag;
    bit neg;
    neg = a[QUAT_WIDTH-1];
    m = neg ? 128'(-$signed(129'(a))) : 128'(a);
    quo = ((m * m) << (2 * FRAC + 2)) / n;
    mag = (isqrt(quo) + 1) >> 1;
    return (neg ^ flip) ? QUAT_WIDTH'(-mag) : QUAT_WIDTH'(mag);
  endfunction

  task automatic rebuild_conj();
    logic signed [127:0] n;
    n = q_x * q_x + q_y * q_y + q_z * q_z + q_w * q_w;
    if (n == 0) begin
      c_x = 0; c_y = 0; c_z = 0; c_w = 0;
    end else begin
      c_x = unit_part(q_x, n, 1);
      c_y = unit_part(q_y, n, 1);
      c_z = unit_part(q_z, n, 1);
      c_w = unit_part(q_w, n, 0);
    end
  endtask

  function automatic rotated_pt_t rotate_point(input logic [3*COORD_WIDTH-1:0] d);
    logic signed [127:0] px, py, pz, tw, tx, ty, tz, r;
    logic signed [127:0] o[3];
    logic signed [127:0] hi_lim, lo_lim;
    logic signed [127:0] qx, qy, qz, qw, cx, cy, cz, cw;
    rotated_pt_t res;
    px = $signed(d[COORD_WIDTH-1:0]);
    py = $signed(d[2*COORD_WIDTH-1:COORD_WIDTH]);
    pz = $signed(d[3*COORD_WIDTH-1:2*COORD_WIDTH]);
    qx = q_x; qy = q_y; qz = q_z; qw = q_w;
    cx = c_x; cy = c_y; cz = c_z; cw = c_w;
    tw = -qx * px - qy * py - qz * pz;
    tx = qw * px + qy * pz - qz * py;
    ty = qw * py + qz * px - qx * pz;
    tz = qw * pz + qx * py - qy * px;
    o[0] = tx * cw + tw * cx + ty * cz - tz * cy;
    o[1] = ty * cw + tw * cy + tz * cx - tx * cz;
    o[2] = tz * cw + tw * cz + tx * cy - ty * cx;
    hi_lim = (128'sd1 <<< (COORD_WIDTH - 1)) - 1;
    lo_lim = -(128'sd1 <<< (COORD_WIDTH - 1));
    res = '0;
    for (int k = 0; k < 3; k++) begin
      r = (o[k] + (128'sd1 <<< (2 * FRAC - 1))) >>> (2 * FRAC);
      if (r < lo_lim) begin
        r = lo_lim; res.clipped = 1;
      end else if (r > hi_lim) begin
        r = hi_lim; res.clipped = 1;
      end
      case (k)
        0: res.x = r[COORD_WIDTH-1:0];
        1: res.y = r[COORD_WIDTH-1:0];
        default: res.z = r[COORD_WIDTH-1:0];
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rotated_pt_t got, want;
    if (!rst_n) begin
      q_x = 0; q_y = 0; q_z = 0; q_w = QUAT_WIDTH'(1) << FRAC;
      c_x = 0; c_y = 0; c_z = 0; c_w = QUAT_WIDTH'(1) << FRAC;
      expected_pts.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_pts.push_back(rotate_point(in_tdata[3*COORD_WIDTH-1:0]));
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[3*COORD_WIDTH-1:0]};
        if (expected_pts.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pts.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z
              || got.clipped !== want.clipped) begin
            $display("%0t: mismatch x/y/z/clip expected %h %h %h %b actual %h %h %h %b",
                     $time, want.x, want.y, want.z, want.clipped,
                     got.x, got.y, got.z, got.clipped);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_pts.size();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROT_X: q_x = cfg_data;
          REG_ROT_Y: q_y = cfg_data;
          REG_ROT_Z: q_z = cfg_data;
          REG_ROT_W: q_w = cfg_data;
          default: ;
        endcase
        rebuild_conj();
      end
    end
  end
endmodule

>>> verif/tb_top.sv
// tb_top: stimulus and verdict for quaternion_point_rotation.
// Depends on qpr_pkg, the block and qpr_checker.
`timescale 1ns / 1ps

module tb_top;
  import qpr_pkg::*;

  localparam int CW = 32;
  localparam int QW = 16;
  localparam int DW = ((3 * CW + 7) / 8) * 8;
  localparam int WATCHDOG = 20000;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic out_tvalid, out_tready = 0, out_tuser;
  logic [DW-1:0] out_tdata;
  logic cfg_valid = 0, cfg_ready;
  logic [REG_IDX_W-1:0] cfg_index = REG_ROT_X;
  logic [QW-1:0] cfg_data = '0;
  int fail_count, pending;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit rx_long = 0;

  always #5 clk = ~clk;

  quaternion_point_rotation #(.COORD_WIDTH(CW), .QUAT_WIDTH(QW)) dut (.*);

  qpr_checker #(.COORD_WIDTH(CW), .QUAT_WIDTH(QW)) u_checker (.*);

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [CW-1:0] coord_val();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return CW'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      3: return CW'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_point(input logic [CW-1:0] x, y, z);
    int g;
    in_tvalid <= 1;
    in_tdata  <= DW'({z, y, x});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // drop valid only for a gap; back-to-back keeps it high
    g = gap_len();
    if (g != 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // valid stays high into the next write; the caller drops it after the last one
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [QW-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // block must be drained before the rotation changes
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_rot(input logic [QW-1:0] x, y, z, w);
    drain();
    write_reg(REG_ROT_X, x);
    write_reg(REG_ROT_Y, y);
    write_reg(REG_ROT_Z, z);
    write_reg(REG_ROT_W, w);
    cfg_valid <= 0;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (rx_long) begin
        out_tready <= 0;
        repeat (300) @(posedge clk);
        rx_long = 0;
      end
      g = gap_len();
      out_tready <= (g == 0);
      @(posedge clk);
      if (g != 0) repeat (g - 1) @(posedge clk);
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // identity after reset: extremes pass straight through
    send_point({1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}}, '0);
    send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
    send_point('1, 32'h7FFF_0000, 32'h8000_0001);

    // 90 degrees about z (unit)
    set_rot(16'h0000, 16'h0000, 16'h2D41, 16'h2D41);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_point({1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}}, 32'h1234_5678);

    // zero quaternion: all outputs zero
    set_rot('0, '0, '0, '0);
    send_point({1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}}, '1);
    send_point(32'h0001_0000, 32'h0, 32'h0);

    // most negative components, non-unit: results scale and saturate
    set_rot(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_point({1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}}, '1);
    send_point(32'h0100_0000, 32'h0, 32'hFF00_0000);
    set_rot(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point({1'b0, {(CW-1){1'b1}}}, 32'h4000_0000, 32'hC000_0000);
    set_rot(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
    send_point({1'b0, {(CW-1){1'b1}}}, {1'b1, {(CW-1){1'b0}}}, 32'h0000_8000);

    // random phases with varied rotations
    for (int ph = 0; ph < 13; ph++) begin
      case (ph % 4)
        0: set_rot(QW'($urandom), QW'($urandom), QW'($urandom), QW'($urandom));
        1: set_rot(QW'($urandom_range(0, 400) - 200), QW'($urandom_range(0, 400) - 200),
                   QW'($urandom), 16'h4000);
        2: set_rot($urandom_range(0, 1) ? 16'h7FFF : 16'h8000, QW'($urandom), '0,
                   $urandom_range(0, 1) ? 16'h8000 : 16'h0001);
        default: set_rot(16'h0000, 16'h0000, 16'h0000, 16'h4000);
      endcase
      if (ph == 5) rx_long = 1;   // receiver stalls long; sender keeps offering
      for (int i = 0; i < 150; i++) send_point(coord_val(), coord_val(), coord_val());
      if (ph == 8) begin
        // sender pause until all results are back
        in_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end

    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
